// ----- design/assert_macros.svh -----
// Concurrent assertion wrappers, clocked on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define QRS_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("qrs assertion failed");
`define QRS_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk_i) prop) \
  else $error("qrs reset assertion failed");
`else
`define QRS_ASSERT(lbl, prop)
`define QRS_ASSERT_RST(lbl, prop)
`endif
`endif

// ----- design/qrs_pkg.sv -----
`default_nettype none
package qrs_pkg;
  localparam int unsigned OUT_WIDTH = 48;

  typedef enum logic [1:0] {
    CLS_NONE    = 2'd0,
    CLS_REPEAT  = 2'd1,
    CLS_REAL    = 2'd2,
    CLS_COMPLEX = 2'd3
  } root_class_e;
endpackage
`default_nettype wire

// ----- design/qrs_sqrt.sv -----
`default_nettype none
module qrs_sqrt #(
  parameter int unsigned RW     = 33,
  parameter int unsigned SIDE_W = 34
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [2*RW-1:0]   rad_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [RW-1:0]          root_o,
  output logic [SIDE_W-1:0]      side_o
);
  import qrs_pkg::*;

  logic              val_s  [RW+1];
  logic [RW+1:0]     rem_s  [RW+1];
  logic [RW-1:0]     root_s [RW+1];
  logic [2*RW-1:0]   rad_s  [RW+1];
  logic [SIDE_W-1:0] side_s [RW+1];

  assign val_s[0]  = valid_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = rad_i;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0] remn, trial;
    logic          ge;

    always_comb begin
      remn  = {rem_s[k][RW-1:0], rad_s[k][2*RW-1 -: 2]};
      trial = {root_s[k], 2'b01};
      ge    = (remn >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val_s[k+1] <= 1'b0;
      end else if (en_i) begin
        val_s[k+1] <= val_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1]  <= ge ? (remn - trial) : remn;
        root_s[k+1] <= {root_s[k][RW-2:0], ge};
        rad_s[k+1]  <= {rad_s[k][2*RW-3:0], 2'b00};
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign valid_o = val_s[RW];
  assign root_o  = root_s[RW];
  assign side_o  = side_s[RW];
endmodule
`default_nettype wire

// ----- design/qrs_div.sv -----
`default_nettype none
module qrs_div #(
  parameter int unsigned NW     = 35,
  parameter int unsigned DENW   = 17,
  parameter int unsigned SIDE_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [NW-1:0]     num1_i,
  input  wire logic [NW-1:0]     num2_i,
  input  wire logic [DENW-1:0]   den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [NW-1:0]          quo1_o,
  output logic [NW-1:0]          quo2_o,
  output logic [SIDE_W-1:0]      side_o
);
  import qrs_pkg::*;

  logic              val_s  [NW+1];
  logic [NW-1:0]     n1_s   [NW+1];
  logic [NW-1:0]     n2_s   [NW+1];
  logic [DENW-1:0]   r1_s   [NW+1];
  logic [DENW-1:0]   r2_s   [NW+1];
  logic [DENW-1:0]   den_s  [NW+1];
  logic [SIDE_W-1:0] side_s [NW+1];

  assign val_s[0]  = valid_i;
  assign n1_s[0]   = num1_i;
  assign n2_s[0]   = num2_i;
  assign r1_s[0]   = '0;
  assign r2_s[0]   = '0;
  assign den_s[0]  = den_i;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DENW:0] rn1, rn2, dx;
    logic          ge1, ge2;

    always_comb begin
      dx  = {1'b0, den_s[k]};
      rn1 = {r1_s[k], n1_s[k][NW-1]};
      rn2 = {r2_s[k], n2_s[k][NW-1]};
      ge1 = (rn1 >= dx);
      ge2 = (rn2 >= dx);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val_s[k+1] <= 1'b0;
      end else if (en_i) begin
        val_s[k+1] <= val_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r1_s[k+1]   <= ge1 ? DENW'(rn1 - dx) : DENW'(rn1);
        r2_s[k+1]   <= ge2 ? DENW'(rn2 - dx) : DENW'(rn2);
        n1_s[k+1]   <= {n1_s[k][NW-2:0], ge1};
        n2_s[k+1]   <= {n2_s[k][NW-2:0], ge2};
        den_s[k+1]  <= den_s[k];
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign valid_o = val_s[NW];
  assign quo1_o  = n1_s[NW];
  assign quo2_o  = n2_s[NW];
  assign side_o  = side_s[NW];
endmodule
`default_nettype wire

// ----- design/quadratic_root_solver.sv -----
// Quadratic root solver.
// Input channel: in_valid_i/in_ready_o with coefficients coef_a_i, coef_b_i,
// coef_c_i (signed integers). Output channel: out_valid_o/out_ready_i with
// root_class_o and first_value_o/second_value_o in signed Q.FRAC_BITS, truncated
// toward zero and saturated to 48 bits.
// One result per transaction, in order. The pipeline takes one transaction
// per cycle and carries a valid bit in every stage.
// Pipeline stages, in order: input register, multiply, discriminant, one stage
// per root bit of the square root (COEF_WIDTH+FRAC_BITS+1), numerator forming,
// one stage per quotient bit of the dual divider (COEF_WIDTH+FRAC_BITS+3),
// output register.
// When the receiver stalls with a result held, the whole pipeline holds and
// in_ready_o drops; bubbles in the pipeline still advance when out_valid_o is
// low. Reset clears every valid bit; no result is shown after reset until a
// transaction has passed through.
`default_nettype none
`include "assert_macros.svh"
module quadratic_root_solver #(
  parameter int unsigned COEF_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [COEF_WIDTH-1:0]  coef_a_i,
  input  wire logic signed [COEF_WIDTH-1:0]  coef_b_i,
  input  wire logic signed [COEF_WIDTH-1:0]  coef_c_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         root_class_o,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] first_value_o,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] second_value_o
);
  import qrs_pkg::*;

  localparam int unsigned RW   = COEF_WIDTH + FRAC_BITS + 1;
  localparam int unsigned NW   = COEF_WIDTH + FRAC_BITS + 3;
  localparam int unsigned PW   = 2 * COEF_WIDTH;
  localparam int unsigned DW   = 2 * COEF_WIDTH + 1;
  localparam int unsigned DENW = COEF_WIDTH + 1;
  localparam int unsigned SW   = (NW + 1 > OUT_WIDTH + 1) ? NW + 1 : OUT_WIDTH + 1;

  typedef struct packed {
    root_class_e           cls;
    logic [COEF_WIDTH-1:0] a;
    logic [COEF_WIDTH-1:0] b;
  } sq_side_t;

  typedef struct packed {
    root_class_e cls;
    logic        neg1;
    logic        neg2;
  } dv_side_t;

  logic en;

  // input register
  logic                         v0_q;
  logic signed [COEF_WIDTH-1:0] a0_q, b0_q, c0_q;
  // products
  logic                         v1_q;
  logic signed [PW-1:0]         bb1_q, ac1_q;
  logic signed [COEF_WIDTH-1:0] a1_q, b1_q;
  // discriminant
  logic                         v2_q;
  logic [DW-1:0]                mag2_q;
  sq_side_t                     side2_q;
  logic signed [PW+2:0]         disc;
  root_class_e                  cls2_d;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_comb begin
    disc = (PW+3)'(bb1_q) - ((PW+3)'(ac1_q) <<< 2);
    priority if (a1_q == '0) begin
      cls2_d = CLS_NONE;
    end else if (disc == '0) begin
      cls2_d = CLS_REPEAT;
    end else if (!disc[PW+2]) begin
      cls2_d = CLS_REAL;
    end else begin
      cls2_d = CLS_COMPLEX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q        <= coef_a_i;
      b0_q        <= coef_b_i;
      c0_q        <= coef_c_i;
      bb1_q       <= b0_q * b0_q;
      ac1_q       <= a0_q * c0_q;
      a1_q        <= a0_q;
      b1_q        <= b0_q;
      mag2_q      <= disc[PW+2] ? DW'(-disc) : DW'(disc);
      side2_q.cls <= cls2_d;
      side2_q.a   <= a1_q;
      side2_q.b   <= b1_q;
    end
  end

  // square root of |d| * 2^(2F)
  logic            vsq;
  logic [RW-1:0]   root_sq;
  sq_side_t        side_sq;
  logic [$bits(sq_side_t)-1:0] side_sq_raw;

  qrs_sqrt #(
    .RW     (RW),
    .SIDE_W ($bits(sq_side_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .rad_i   ({1'b0, mag2_q, {(2*FRAC_BITS){1'b0}}}),
    .side_i  (side2_q),
    .valid_o (vsq),
    .root_o  (root_sq),
    .side_o  (side_sq_raw)
  );

  assign side_sq = sq_side_t'(side_sq_raw);

  // numerators
  logic signed [NW-1:0] bs, rr, n1, n2;
  logic                 vn_q;
  logic [NW-1:0]        n1m_q, n2m_q;
  logic [DENW-1:0]      den_q;
  dv_side_t             sidn_q;
  logic [DENW-1:0]      amag;

  always_comb begin
    bs   = NW'($signed(side_sq.b)) <<< FRAC_BITS;
    rr   = $signed({2'b00, root_sq});
    n1   = ((side_sq.cls == CLS_REAL) ? rr : '0) - bs;
    n2   = (side_sq.cls == CLS_REAL) ? (-rr - bs) : rr;
    amag = side_sq.a[COEF_WIDTH-1] ? DENW'(-$signed(side_sq.a)) : DENW'(side_sq.a);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else if (en) begin
      vn_q <= vsq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1m_q       <= n1[NW-1] ? NW'(-n1) : NW'(n1);
      n2m_q       <= n2[NW-1] ? NW'(-n2) : NW'(n2);
      den_q       <= {amag[DENW-2:0], 1'b0};
      sidn_q.cls  <= side_sq.cls;
      sidn_q.neg1 <= n1[NW-1] ^ side_sq.a[COEF_WIDTH-1];
      sidn_q.neg2 <= n2[NW-1] ^ side_sq.a[COEF_WIDTH-1];
    end
  end

  // division by 2a
  logic          vdv;
  logic [NW-1:0] q1, q2;
  dv_side_t      side_dv;
  logic [$bits(dv_side_t)-1:0] side_dv_raw;

  qrs_div #(
    .NW     (NW),
    .DENW   (DENW),
    .SIDE_W ($bits(dv_side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vn_q),
    .num1_i  (n1m_q),
    .num2_i  (n2m_q),
    .den_i   (den_q),
    .side_i  (sidn_q),
    .valid_o (vdv),
    .quo1_o  (q1),
    .quo2_o  (q2),
    .side_o  (side_dv_raw)
  );

  assign side_dv = dv_side_t'(side_dv_raw);

  // sign, saturate, output register
  logic signed [SW-1:0]        s1, s2, omax, omin;
  logic signed [OUT_WIDTH-1:0] f_d, s_d;
  logic                        out_valid_q;
  root_class_e                 cls_q;
  logic signed [OUT_WIDTH-1:0] first_q, second_q;

  always_comb begin
    omax = $signed({{(SW-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}});
    omin = ~omax;
    s1   = SW'($signed(side_dv.neg1 ? -{1'b0, q1} : {1'b0, q1}));
    s2   = SW'($signed(side_dv.neg2 ? -{1'b0, q2} : {1'b0, q2}));
    priority if (s1 > omax) begin
      f_d = omax[OUT_WIDTH-1:0];
    end else if (s1 < omin) begin
      f_d = omin[OUT_WIDTH-1:0];
    end else begin
      f_d = s1[OUT_WIDTH-1:0];
    end
    priority if (s2 > omax) begin
      s_d = omax[OUT_WIDTH-1:0];
    end else if (s2 < omin) begin
      s_d = omin[OUT_WIDTH-1:0];
    end else begin
      s_d = s2[OUT_WIDTH-1:0];
    end
    unique case (side_dv.cls)
      CLS_NONE: begin
        f_d = '0;
        s_d = '0;
      end
      CLS_REPEAT: begin
        s_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vdv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cls_q    <= side_dv.cls;
      first_q  <= f_d;
      second_q <= s_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign root_class_o   = cls_q;
  assign first_value_o  = first_q;
  assign second_value_o = second_q;

  `QRS_ASSERT(a_none_zero, out_valid_o && (cls_q == CLS_NONE) |-> (first_q == '0) && (second_q == '0))
  `QRS_ASSERT(a_rep_zero, out_valid_o && (cls_q == CLS_REPEAT) |-> (second_q == '0))
  `QRS_ASSERT(a_accept, in_valid_i && in_ready_o |=> v0_q)
  `QRS_ASSERT_RST(a_rst, !rst_ni |=> !out_valid_o)
endmodule
`default_nettype wire

// ----- tb/qrs_checker.sv -----
`default_nettype none
module qrs_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic signed [15:0] coef_a_i,
  input  wire logic signed [15:0] coef_b_i,
  input  wire logic signed [15:0] coef_c_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic [1:0]         root_class_i,
  input  wire logic signed [47:0] first_value_i,
  input  wire logic signed [47:0] second_value_i,
  output int                      errors_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam longint VAL_MAX = (longint'(1) <<< 47) - 1;
  localparam longint VAL_MIN = -VAL_MAX - 1;

  typedef struct packed {
    qrs_pkg::root_class_e cls;
    logic signed [47:0]   first;
    logic signed [47:0]   second;
  } roots_t;

  roots_t roots_q[$];

  function automatic logic [63:0] isqrt_scaled(input logic [63:0] mag);
    logic [127:0] n;
    logic [127:0] rem;
    logic [127:0] root;
    logic [127:0] trial;
    n = {64'd0, mag} << (2 * FRAC);
    rem = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((n >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  function automatic logic signed [47:0] clamp48(input longint v);
    if (v > VAL_MAX) v = VAL_MAX;
    if (v < VAL_MIN) v = VAL_MIN;
    return v[47:0];
  endfunction

  function automatic roots_t solve_roots(input logic signed [15:0] ca,
                                         input logic signed [15:0] cb,
                                         input logic signed [15:0] cc);
    roots_t res;
    longint a, b, c, den, bs, d, r, f, s;
    a = ca;
    b = cb;
    c = cc;
    f = 0;
    s = 0;
    res.cls = qrs_pkg::CLS_NONE;
    if (a != 0) begin
      den = 2 * a;
      bs = b <<< FRAC;
      d = b * b - 4 * a * c;
      if (d == 0) begin
        res.cls = qrs_pkg::CLS_REPEAT;
        f = (-bs) / den;
      end else if (d > 0) begin
        r = longint'(isqrt_scaled(d));
        res.cls = qrs_pkg::CLS_REAL;
        f = (r - bs) / den;
        s = (-r - bs) / den;
      end else begin
        r = longint'(isqrt_scaled(-d));
        res.cls = qrs_pkg::CLS_COMPLEX;
        f = (-bs) / den;
        s = r / den;
      end
    end
    res.first = clamp48(f);
    res.second = clamp48(s);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    roots_t want;
    if (!rst_ni) begin
      roots_q.delete();
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) roots_q.push_back(solve_roots(coef_a_i, coef_b_i, coef_c_i));
      if (out_valid_i && out_ready_i) begin
        if (roots_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result: class %0d first %0d second %0d",
                                      root_class_i, first_value_i, second_value_i);
          errors_o <= errors_o + 1;
        end else begin
          want = roots_q.pop_front();
          if (root_class_i !== want.cls || first_value_i !== want.first ||
              second_value_i !== want.second) begin
            if (errors_o < 10)
              $display("mismatch: class %0d/%0d first %0d/%0d second %0d/%0d (exp/act)",
                       want.cls, root_class_i, want.first, first_value_i,
                       want.second, second_value_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= roots_q.size();
    end
  end
endmodule
`default_nettype wire

// ----- tb/quadratic_root_solver_tb.sv -----
`default_nettype none
module quadratic_root_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 73;
  localparam int STALL_LIMIT = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] coef_a_i = '0;
  logic signed [15:0] coef_b_i = '0;
  logic signed [15:0] coef_c_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] root_class_o;
  logic signed [47:0] first_value_o;
  logic signed [47:0] second_value_o;
  int errors;
  int pending;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  quadratic_root_solver dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .coef_a_i, .coef_b_i, .coef_c_i,
    .out_valid_o, .out_ready_i, .root_class_o, .first_value_o, .second_value_o
  );

  qrs_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .coef_a_i, .coef_b_i,
    .coef_c_i, .out_valid_i(out_valid_o), .out_ready_i, .root_class_i(root_class_o),
    .first_value_i(first_value_o), .second_value_i(second_value_o),
    .errors_o(errors), .pending_o(pending)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(input logic signed [15:0] a, input logic signed [15:0] b,
                      input logic signed [15:0] c, input bit calm);
    bit seen;
    int g;
    in_valid_i <= 1'b1;
    coef_a_i <= a;
    coef_b_i <= b;
    coef_c_i <= c;
    do begin
      @(negedge clk_i);
      seen = in_ready_o;
      @(posedge clk_i);
    end while (!seen);
    g = calm ? 0 : gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_random(input bit calm);
    int p, m, k;
    logic signed [15:0] a, b, c;
    p = $urandom_range(99);
    a = 16'($urandom);
    b = 16'($urandom);
    c = 16'($urandom);
    if (p < 8) begin
      a = 0;
    end else if (p < 25) begin
      m = $urandom_range(1, 60);
      k = $urandom_range(0, 23);
      a = 16'(($urandom_range(1) != 0) ? m : -m);
      b = 16'(2 * a * k * (($urandom_range(1) != 0) ? 1 : -1));
      c = 16'(a * k * k);
    end else if (p < 45) begin
      a = 16'(int'($urandom_range(0, 200)) - 100);
      b = 16'(int'($urandom_range(0, 2000)) - 1000);
      c = 16'(int'($urandom_range(0, 2000)) - 1000);
      if (a == 0) a = 1;
    end else if (p < 50) begin
      a = ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
      b = ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
    end
    send(a, b, c, calm);
  endtask

  initial begin
    int burst;
    bit calm;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    send(0, 16'sh7fff, 16'sh8000, 0);
    send(0, 0, 0, 0);
    send(1, 0, 0, 0);
    send(-32768, 0, 0, 0);
    send(1, 2, 1, 0);
    send(1, -2, 1, 0);
    send(-3, 6, -3, 0);
    send(1, -3, 2, 0);
    send(2, 5, -3, 0);
    send(-32768, 32767, 32767, 0);
    send(32767, -32768, -32768, 0);
    send(1, 0, -32768, 0);
    send(1, 0, 1, 0);
    send(-1, 0, -1, 0);
    send(3, 1, 5, 0);
    send(32767, 32767, 32767, 0);
    send(-32768, -32768, -32768, 0);
    send(1, 32767, 32767, 0);
    send(-1, -32768, 1, 0);
    hold_req <= 1'b1;
    for (int i = 0; i < 150; i++) send_random(1);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
    burst = 0;
    calm = 0;
    for (int i = 0; i < 380; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(10, 60);
        calm = ($urandom_range(3) == 0);
      end
      burst--;
      send_random(calm);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int g;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      g = gap_len();
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire
